[src/offload_enable_hysteresis_fsm_macros.svh]
// Assertion helpers for the top module of the offload enable block.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef OFFLOAD_ENABLE_HYSTERESIS_FSM_MACROS_SVH
`define OFFLOAD_ENABLE_HYSTERESIS_FSM_MACROS_SVH

// Same-cycle implication.
`define OHF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("offload enable block: same-cycle check failed");

// Next-cycle implication.
`define OHF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("offload enable block: next-cycle check failed");

`endif

[src/ohf_pkg.sv]
`timescale 1ns / 1ps

package ohf_pkg;

	localparam int ByteRateW   = 40;
	localparam int PacketRateW = 32;
	localparam int UtilW       = 7;
	localparam int TicksW      = 16;
	localparam int ModeW       = 2;
	localparam int CfgDataW    = 64;
	localparam int CfgAddrW    = 5;

	localparam logic [ModeW-1:0] MODE_INIT         = 2'd0;
	localparam logic [ModeW-1:0] MODE_INACTIVE     = 2'd1;
	localparam logic [ModeW-1:0] MODE_ACTIVE       = 2'd2;
	localparam logic [ModeW-1:0] MODE_DEACTIVATING = 2'd3;

	localparam logic [0:0] KIND_SAMPLE = 1'b0;
	localparam logic [0:0] KIND_TICK   = 1'b1;

	// Register slots, taken from paddr[4:3].
	localparam logic [1:0] REG_MIN_BYTE_RATE    = 2'd0;
	localparam logic [1:0] REG_UTIL_THRESHOLD   = 2'd1;
	localparam logic [1:0] REG_DEACTIVATE_TICKS = 2'd2;

	// 100 Mibit/s (100 * 1024 * 1024 bits) expressed in bytes per second.
	localparam logic [ByteRateW-1:0] MIN_BYTE_RATE_RST    = ByteRateW'(100 * 1024 * 1024 / 8);
	localparam logic [UtilW-1:0]     UTIL_THRESHOLD_RST   = UtilW'(80);
	localparam logic [TicksW-1:0]    DEACTIVATE_TICKS_RST = TicksW'(5);

	typedef struct packed {
		logic                   kind;
		logic [ByteRateW-1:0]   byte_rate;
		logic [PacketRateW-1:0] packet_rate;
		logic [UtilW-1:0]       util_percent;
		logic                   cpu_valid;
	} sample_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic             mode_changed;
	} result_t;

	typedef struct packed {
		logic [ByteRateW-1:0] min_byte_rate;
		logic [UtilW-1:0]     util_threshold;
		logic [TicksW-1:0]    deactivate_ticks;
	} cfg_t;

endpackage

[src/ohf_decide.sv]
`timescale 1ns / 1ps

module ohf_decide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  ohf_pkg::sample_t item,
	input  ohf_pkg::cfg_t    cfg,
	output ohf_pkg::result_t result
);

	logic [ohf_pkg::ModeW-1:0]       mode_q, mode_n;
	logic [ohf_pkg::ByteRateW-1:0]   byte_wm_q, byte_wm_n;
	logic [ohf_pkg::PacketRateW-1:0] packet_wm_q, packet_wm_n;
	logic [ohf_pkg::UtilW-1:0]       held_util_q, held_util_n;
	logic [ohf_pkg::TicksW-1:0]      grace_count_q, grace_count_n;
	logic                            grace_elapsed_q, grace_elapsed_n;
	logic                            below;
	logic [ohf_pkg::UtilW-1:0]       util_eff;

	assign below = (item.byte_rate < byte_wm_q) || (item.packet_rate < packet_wm_q);
	assign util_eff = item.cpu_valid ? item.util_percent : held_util_q;

	always_comb begin
		mode_n          = mode_q;
		byte_wm_n       = byte_wm_q;
		packet_wm_n     = packet_wm_q;
		held_util_n     = held_util_q;
		grace_count_n   = grace_count_q;
		grace_elapsed_n = grace_elapsed_q;
		if (item.kind == ohf_pkg::KIND_TICK) begin
			// A tick only runs the grace countdown down.
			if (grace_count_q != '0) begin
				grace_count_n = grace_count_q - 1'b1;
				if (grace_count_q == ohf_pkg::TicksW'(1)) begin
					grace_elapsed_n = 1'b1;
				end
			end
		end else if (mode_q == ohf_pkg::MODE_INIT) begin
			// The first sample is not examined at all.
			mode_n = ohf_pkg::MODE_INACTIVE;
		end else begin
			held_util_n = util_eff;
			case (mode_q)
				ohf_pkg::MODE_INACTIVE: begin
					if (item.byte_rate > cfg.min_byte_rate && util_eff > cfg.util_threshold) begin
						byte_wm_n   = item.byte_rate >> 1;
						packet_wm_n = item.packet_rate >> 1;
						mode_n      = ohf_pkg::MODE_ACTIVE;
					end
				end
				ohf_pkg::MODE_ACTIVE: begin
					if (below) begin
						grace_count_n   = cfg.deactivate_ticks;
						grace_elapsed_n = (cfg.deactivate_ticks == '0);
						mode_n          = ohf_pkg::MODE_DEACTIVATING;
					end
				end
				ohf_pkg::MODE_DEACTIVATING: begin
					if (!below) begin
						grace_count_n   = '0;
						grace_elapsed_n = 1'b0;
						mode_n          = ohf_pkg::MODE_ACTIVE;
					end else if (grace_elapsed_q) begin
						mode_n = ohf_pkg::MODE_INACTIVE;
					end
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end
	end

	assign result.mode         = mode_n;
	assign result.mode_changed = (mode_n != mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= ohf_pkg::MODE_INIT;
			byte_wm_q       <= '0;
			packet_wm_q     <= '0;
			held_util_q     <= '0;
			grace_count_q   <= '0;
			grace_elapsed_q <= 1'b0;
		end else if (fire) begin
			mode_q          <= mode_n;
			byte_wm_q       <= byte_wm_n;
			packet_wm_q     <= packet_wm_n;
			held_util_q     <= held_util_n;
			grace_count_q   <= grace_count_n;
			grace_elapsed_q <= grace_elapsed_n;
		end
	end

endmodule

[src/offload_enable_hysteresis_fsm.sv]
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// sample    sample_valid, sample_stall, sample        in  (stall driven here)
// result    result_valid, result_stall, result        out (stall driven outside)
// config    psel, penable, pwrite, paddr, pwdata,     APB slave, 64-bit data,
//           prdata, pready                            registers at 0x00/0x08/0x10
//
// Every item produces exactly one result; an accepted item waits in the input register,
// passes the decision into the result register and then raises result_valid.
// One item is accepted per cycle as long as the result side keeps taking transfers.
// Reset is asynchronous and active low; it puts the mode to init and loads
// the register defaults. A stall on the result side holds the result register,
// and the input register then holds one more item before sample_stall rises.

`include "offload_enable_hysteresis_fsm_macros.svh"

module offload_enable_hysteresis_fsm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  ohf_pkg::sample_t                      sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output ohf_pkg::result_t                      result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ohf_pkg::CfgAddrW-1:0]          paddr,
	input  logic [ohf_pkg::CfgDataW-1:0]          pwdata,
	output logic [ohf_pkg::CfgDataW-1:0]          prdata,
	output logic                                  pready
);

	ohf_pkg::cfg_t    cfg_q;
	logic             cfg_write;
	logic [1:0]       reg_sel;

	logic             valid_s1;
	ohf_pkg::sample_t item_s1;
	logic             advance;
	logic             accept;
	logic             result_valid_q;
	ohf_pkg::result_t result_q;
	ohf_pkg::result_t result_n;
	logic             result_is_init;

	// Configuration registers
	assign pready    = 1'b1;
	assign reg_sel   = paddr[4:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_byte_rate    <= ohf_pkg::MIN_BYTE_RATE_RST;
			cfg_q.util_threshold   <= ohf_pkg::UTIL_THRESHOLD_RST;
			cfg_q.deactivate_ticks <= ohf_pkg::DEACTIVATE_TICKS_RST;
		end else if (cfg_write) begin
			case (reg_sel)
				ohf_pkg::REG_MIN_BYTE_RATE: begin
					cfg_q.min_byte_rate <= pwdata[ohf_pkg::ByteRateW-1:0];
				end
				ohf_pkg::REG_UTIL_THRESHOLD: begin
					cfg_q.util_threshold <= pwdata[ohf_pkg::UtilW-1:0];
				end
				ohf_pkg::REG_DEACTIVATE_TICKS: begin
					cfg_q.deactivate_ticks <= pwdata[ohf_pkg::TicksW-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ohf_pkg::REG_MIN_BYTE_RATE: begin
				prdata = ohf_pkg::CfgDataW'(cfg_q.min_byte_rate);
			end
			ohf_pkg::REG_UTIL_THRESHOLD: begin
				prdata = ohf_pkg::CfgDataW'(cfg_q.util_threshold);
			end
			ohf_pkg::REG_DEACTIVATE_TICKS: begin
				prdata = ohf_pkg::CfgDataW'(cfg_q.deactivate_ticks);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Item flow: input register, then the decision into the result register.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	ohf_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign result_is_init = result_valid_q && (result_q.mode == ohf_pkg::MODE_INIT);

	`OHF_ASSERT_NEXT(a_advance_fills_result, advance, result_valid_q)
	`OHF_ASSERT_SAME(a_stall_only_when_full, sample_stall, valid_s1 && result_valid_q && result_stall)
	`OHF_ASSERT_SAME(a_init_never_changed, result_is_init, !result_q.mode_changed)

endmodule
